### hw/rtl/uws_pkg.sv
// uws_pkg: shared constants and types for the unsigned word sorter.
// Used by uws_if.sv, uws_cell.sv and unsigned_word_sorter.sv; depends on nothing.
`timescale 1ns / 1ps

package uws_pkg;

  // Default number of sort cells; legal range is 2 to 64
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned WORD_W       = 32;

  // Per-cycle operation applied to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  // Control bundle sent from the top level to one cell
  typedef struct packed {
    cell_op_t op;
    logic     occupied;       // this cell holds a value
    logic     prev_occupied;  // the cell below holds a value (1 for cell 0)
  } cell_ctl_t;

endpackage : uws_pkg

### hw/rtl/uws_if.sv
// uws_in_if / uws_out_if: valid/ready channels of the unsigned word sorter.
// Depends on uws_pkg for the word width.
`timescale 1ns / 1ps

interface uws_in_if;
  logic                       valid;
  logic                       ready;
  logic [uws_pkg::WORD_W-1:0] value;
  logic                       last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface : uws_in_if

interface uws_out_if;
  logic                       valid;
  logic                       ready;
  logic [uws_pkg::WORD_W-1:0] sorted_value;
  logic                       last_out;
  logic                       overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface : uws_out_if

### hw/rtl/unsigned_word_sorter.sv
// unsigned_word_sorter: top level, a chain of CAPACITY insertion cells plus
// the load/drain control. Depends on uws_pkg, uws_if.sv and uws_cell.sv.
//
//  channel  | dir | signals                                      | transaction
//  ---------+-----+----------------------------------------------+----------------------
//  in_ch    | in  | valid, ready, value[31:0], last_in           | one word to sort
//  out_ch   | out | valid, ready, sorted_value[31:0], last_out,  | one word, ascending
//           |     | overflow                                     |
//
// Each accepted word is inserted by the whole chain: every cell compares
// against the new word in parallel and the larger ones move up by one.
// After the word with last_in, the set drains from cell 0, one word per cycle
// the sink accepts; in_ch.ready is low from that edge until the final word leaves.
// Reset (rst_n low, synchronous) empties the store and clears the overflow flag.
// out_ch stalls hold the chain; words beyond CAPACITY are dropped and flagged.
`timescale 1ns / 1ps

module unsigned_word_sorter #(
  parameter int unsigned CAPACITY = uws_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  uws_in_if.sink    in_ch,
  uws_out_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 dropped_r, dropped_nxt;

  logic                 in_fire;
  logic                 out_fire;
  logic                 full;
  logic                 last_word;
  uws_pkg::cell_op_t    op;

  logic [uws_pkg::WORD_W-1:0] cell_value   [CAPACITY];
  logic                       cell_greater [CAPACITY];

  // Handshakes
  assign in_ch.ready  = (state_r == ST_LOAD);
  assign out_ch.valid = (state_r == ST_DRAIN);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign full         = (count_r == CNT_W'(CAPACITY));
  assign last_word    = (count_r == CNT_W'(1));

  // Chain operation for this cycle
  always_comb begin
    op = uws_pkg::CELL_HOLD;
    if (in_fire && !full) begin
      op = uws_pkg::CELL_INSERT;
    end else if (out_fire) begin
      op = uws_pkg::CELL_SHIFT;
    end
  end

  // Cell chain: cell 0 holds the smallest word
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    uws_pkg::cell_ctl_t         ctl;
    logic [uws_pkg::WORD_W-1:0] prev_value;
    logic                       prev_greater;
    logic [uws_pkg::WORD_W-1:0] next_value;

    assign ctl.op       = op;
    assign ctl.occupied = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign ctl.prev_occupied = 1'b1;
      assign prev_value        = '0;
      assign prev_greater      = 1'b0;
    end else begin : g_rest
      assign ctl.prev_occupied = (CNT_W'(i - 1) < count_r);
      assign prev_value        = cell_value[i-1];
      assign prev_greater      = cell_greater[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign next_value = '0;
    end else begin : g_mid
      assign next_value = cell_value[i+1];
    end

    uws_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .ins_value    (in_ch.value),
      .prev_value   (prev_value),
      .prev_greater (prev_greater),
      .next_value   (next_value),
      .value        (cell_value[i]),
      .greater      (cell_greater[i])
    );
  end

  // Next state, fill count and sticky drop flag
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_ch.last_in) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          count_nxt = count_r - CNT_W'(1);
          if (last_word) begin
            state_nxt   = ST_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Result payload: the word straight from cell 0, plus the last and overflow flags
  assign out_ch.sorted_value = cell_value[0];
  assign out_ch.last_out     = last_word;
  assign out_ch.overflow     = dropped_r;

  // Checks
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (count_r != '0))
    else $error("drain with empty store");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_drop_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full) |=> dropped_r)
    else $error("dropped word not flagged");

  a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && last_word) |=> (in_ch.ready && (count_r == '0) && !dropped_r))
    else $error("store not emptied after final word");

endmodule : unsigned_word_sorter

### hw/rtl/uws_cell.sv
// uws_cell: one cell of the insertion chain, holding a single sorted word.
// Depends on uws_pkg for cell_ctl_t and the word width.
`timescale 1ns / 1ps

module uws_cell (
  input  logic                       clk,
  input  uws_pkg::cell_ctl_t         ctl,
  input  logic [uws_pkg::WORD_W-1:0] ins_value,     // word being inserted
  input  logic [uws_pkg::WORD_W-1:0] prev_value,    // value of the cell below
  input  logic                       prev_greater,  // cell below holds a larger word
  input  logic [uws_pkg::WORD_W-1:0] next_value,    // value of the cell above
  output logic [uws_pkg::WORD_W-1:0] value,
  output logic                       greater
);

  logic [uws_pkg::WORD_W-1:0] value_r;
  logic [uws_pkg::WORD_W-1:0] value_nxt;
  logic                       place;

  // Larger than the incoming word: this cell moves up by one
  assign greater = ctl.occupied && (value_r > ins_value);

  // New word lands here when the chain below is smaller or equal and this
  // cell is either larger or the first free one
  assign place = !prev_greater && ctl.prev_occupied && (greater || !ctl.occupied);

  always_comb begin
    value_nxt = value_r;
    case (ctl.op)
      uws_pkg::CELL_INSERT: begin
        if (prev_greater) begin
          value_nxt = prev_value;
        end else if (place) begin
          value_nxt = ins_value;
        end
      end
      uws_pkg::CELL_SHIFT: begin
        value_nxt = next_value;
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule : uws_cell
